FILE: rtl/sscm_pkg.sv
// package for the spi slave command mailbox
// item types, register indexes and command codes; no dependencies
package sscm_pkg;

   localparam int unsigned RING_DEPTH_DEFAULT = 8;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [BYTE_W-1:0] ACK_CODE_RESET  = 8'd6;
   localparam logic [BYTE_W-1:0] NACK_CODE_RESET = 8'd21;

   localparam logic [BYTE_W-1:0] REQ_STATUS = 8'hC1;
   localparam logic [BYTE_W-1:0] CMD_FIRST  = 8'hA1;
   localparam logic [BYTE_W-1:0] CMD_LAST   = 8'hA3;
   localparam logic [BYTE_W-1:0] CMD_BASE   = 8'hA0;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_SHIFT   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_CODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NACK_CODE = 1'b1;

   localparam logic [ACTION_W-1:0] ACTION_NONE = 2'd0;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic                tx_valid;
      logic [BYTE_W-1:0]   tx_byte;
      logic                enqueue_busy;
      logic                attention_low;
      logic [ACTION_W-1:0] action;
   } rsp_type;

endpackage

FILE: rtl/sscm_ring_ram.sv
// ring storage for the mailbox: one write port, one registered read port
// depends on sscm_pkg for the byte width
module sscm_ring_ram
   import sscm_pkg::*;
#(
   parameter int unsigned DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_W-1:0]        rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/spi_slave_command_mailbox_unit.sv
// spi slave command mailbox: an accepted item is registered, and the result register loads when
// the execute step runs; items are handled one at a time: the ring memory read, then execute
// a stalled result holds the execute step; the next item is taken once it completes
// reset is synchronous: pointers, phase, attention line and result valid clear,
// ack and nack codes return to 6 and 21; ring contents are not cleared
// depends on sscm_pkg and sscm_ring_ram
module spi_slave_command_mailbox_unit
   import sscm_pkg::*;
#(
   parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data
);

   localparam int unsigned PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_SENT,
      PH_ACKED
   } phase_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   req_type           item_ff, item_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              line_ff, line_in;
   logic [BYTE_W-1:0] ack_ff, ack_in;
   logic [BYTE_W-1:0] nack_ff, nack_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              exec_go;
   logic              ring_full;
   logic              ring_empty;
   logic              ram_wr_en;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [PTR_W-1:0]  wr_ptr_next;
   logic [PTR_W-1:0]  rd_ptr_next;
   rsp_type           result;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   sscm_ring_ram #(
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (item_ff.data_byte),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign wr_ptr_next = ptr_inc(wr_ptr_ff);
   assign rd_ptr_next = ptr_inc(rd_ptr_ff);
   assign ring_full   = (wr_ptr_next == rd_ptr_ff);
   assign ring_empty  = (wr_ptr_ff == rd_ptr_ff);
   assign exec_go     = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign ram_wr_en   = exec_go && (item_ff.op == OP_ENQUEUE) && !ring_full;

   // item execution
   always_comb begin
      result    = '0;
      phase_in  = phase_ff;
      line_in   = line_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (item_ff.op == OP_ENQUEUE) begin
         if (ring_full) begin
            result.enqueue_busy = 1'b1;
         end else begin
            wr_ptr_in = wr_ptr_next;
         end
         line_in = 1'b1;
      end else begin
         case (phase_ff)
            PH_SENT: begin
               if (ring_empty) begin
                  line_in = 1'b0;
               end
               phase_in = PH_WAIT;
            end
            PH_ACKED: begin
               phase_in = PH_WAIT;
            end
            default: begin
               result.tx_valid = 1'b1;
               if (item_ff.data_byte == REQ_STATUS) begin
                  if (!ring_empty) begin
                     result.tx_byte = ram_rd_data;
                     rd_ptr_in      = rd_ptr_next;
                     phase_in       = PH_SENT;
                  end else begin
                     result.tx_byte = nack_ff;
                     phase_in       = PH_WAIT;
                  end
               end else if (item_ff.data_byte >= CMD_FIRST &&
                            item_ff.data_byte <= CMD_LAST) begin
                  result.tx_byte = ack_ff;
                  result.action  = ACTION_W'(item_ff.data_byte - CMD_BASE);
                  phase_in       = PH_ACKED;
               end else begin
                  result.tx_byte = nack_ff;
               end
            end
         endcase
      end
      result.attention_low = line_in;
   end

   // handshake and register next values
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ack_in       = ack_ff;
      nack_in      = nack_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_valid) begin
         case (csr_index)
            CSR_ACK_CODE:  ack_in  = csr_data;
            CSR_NACK_CODE: nack_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         line_ff      <= 1'b0;
         ack_ff       <= ACK_CODE_RESET;
         nack_ff      <= NACK_CODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ack_ff       <= ack_in;
         nack_ff      <= nack_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            phase_ff  <= phase_in;
            wr_ptr_ff <= wr_ptr_in;
            rd_ptr_ff <= rd_ptr_in;
            line_ff   <= line_in;
         end
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: rtl/sscm_checker.sv
// port-level checks for the spi slave command mailbox, bound to the top level
// depends on sscm_pkg and spi_slave_command_mailbox_unit
module sscm_port_checker
   import sscm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // reset empties the result slot
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no byte loaded means no byte and no action shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |->
         rsp_data.tx_byte == '0 && rsp_data.action == ACTION_NONE)
      else $error("idle result carries data");

   // a dropped enqueue still drives the line and loads nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.enqueue_busy |->
         rsp_data.attention_low && !rsp_data.tx_valid)
      else $error("busy result inconsistent");

   // an item taken is never taken again on the next edge
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken without execution");

endmodule

bind spi_slave_command_mailbox_unit sscm_port_checker u_sscm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
